// File: src/rpd_pkg.sv
// Shared types and constants for the radio packet deframer and parser.
// Depends on nothing; every other file imports it.
package rpd_pkg;

    localparam int IR_COUNT_DEF = 3;
    localparam int IR_KEEP = 3;

    localparam logic [7:0] BYTE_START = 8'h4B;
    localparam logic [7:0] BYTE_SAFE  = 8'h5E;
    localparam logic [7:0] BYTE_SHAKE = 8'h7E;
    localparam logic [7:0] BYTE_END   = 8'h4F;
    localparam logic [7:0] BYTE_FILL  = 8'h7A;
    localparam logic [3:0] HI_IR      = 4'h2;
    localparam logic [3:0] HI_DIGIT   = 4'h3;
    localparam logic [3:0] HI_LETTER  = 4'h4;
    localparam logic [7:0] DIGIT_BASE = 8'h30;
    localparam logic [7:0] LETTER_BASE = 8'h37;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_SAFE  = 4'd1,
        PH_FIRST = 4'd2,
        PH_IR    = 4'd3,
        PH_CHIRP = 4'd4,
        PH_INSTR = 4'd5,
        PH_DONE  = 4'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_SHAKE  = 2'd0,
        ST_FULL   = 2'd1,
        ST_REJECT = 2'd2,
        ST_IRONLY = 2'd3
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] ir_first;
        logic [3:0] ir_second;
        logic [3:0] ir_third;
        logic [7:0] chirp_strength;
        logic [3:0] instruction;
    } result_t;

endpackage

// File: src/rpd_parser.sv
// Frame parser: per-word state machine and the result for a closing word.
// Depends on rpd_pkg.
module rpd_parser #(
    parameter int IR_COUNT = rpd_pkg::IR_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       rx_byte,
    output logic             result_valid,
    output rpd_pkg::result_t result
);
    import rpd_pkg::*;

    localparam int CNT_RAW = $clog2(IR_COUNT + 1);
    localparam int CNT_W = (CNT_RAW < 2) ? 2 : CNT_RAW;

    phase_t         phase_reg, phase_next;
    logic [3:0]     ir_reg [IR_KEEP];
    logic [3:0]     ir_next [IR_KEEP];
    logic [7:0]     chirp_reg, chirp_next;
    logic [3:0]     instr_reg, instr_next;
    status_t        verdict_reg, verdict_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           second_reg, second_next;

    logic [3:0] hi;
    logic [CNT_W-1:0] cnt_inc;
    logic [7:0] digit;
    logic       frame_end;

    assign hi = rx_byte[7:4];
    assign cnt_inc = cnt_reg + 1'b1;
    assign frame_end = (rx_byte == BYTE_END) && (phase_reg != PH_IDLE);

    always_comb
    begin
        if (hi == HI_DIGIT)
        begin
            digit = rx_byte - DIGIT_BASE;
        end
        else if (hi == HI_LETTER)
        begin
            digit = rx_byte - LETTER_BASE;
        end
        else
        begin
            digit = 8'h00;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        ir_next = ir_reg;
        chirp_next = chirp_reg;
        instr_next = instr_reg;
        verdict_next = verdict_reg;
        cnt_next = cnt_reg;
        second_next = second_reg;
        if (take && (rx_byte != BYTE_FILL))
        begin
            if ((rx_byte == BYTE_START) || frame_end)
            begin
                phase_next = (rx_byte == BYTE_START) ? PH_SAFE : PH_IDLE;
                for (int i = 0; i < IR_KEEP; i++)
                begin
                    ir_next[i] = 4'h0;
                end
                chirp_next = 8'h00;
                instr_next = 4'h0;
                verdict_next = ST_REJECT;
                cnt_next = '0;
                second_next = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SAFE:
                    begin
                        phase_next = (rx_byte == BYTE_SAFE) ? PH_FIRST : PH_DONE;
                    end
                    PH_FIRST, PH_IR:
                    begin
                        if ((phase_reg == PH_FIRST) && (rx_byte == BYTE_SHAKE))
                        begin
                            verdict_next = ST_SHAKE;
                            phase_next = PH_DONE;
                        end
                        else if ((phase_reg == PH_IR) || (hi == HI_IR))
                        begin
                            for (int i = 0; i < IR_KEEP; i++)
                            begin
                                if (cnt_reg == CNT_W'(i))
                                begin
                                    ir_next[i] = rx_byte[3:0];
                                end
                            end
                            if (cnt_inc >= CNT_W'(IR_COUNT))
                            begin
                                cnt_next = '0;
                                phase_next = PH_CHIRP;
                            end
                            else
                            begin
                                cnt_next = cnt_inc;
                                phase_next = PH_IR;
                            end
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_CHIRP:
                    begin
                        if (!second_reg && (hi != HI_DIGIT) && (hi != HI_LETTER))
                        begin
                            chirp_next = 8'h00;
                            verdict_next = ST_IRONLY;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            chirp_next = {chirp_reg[3:0], 4'h0} | digit;
                            second_next = !second_reg;
                            if (second_reg)
                            begin
                                phase_next = PH_INSTR;
                            end
                        end
                    end
                    PH_INSTR:
                    begin
                        instr_next = rx_byte[3:0];
                        verdict_next = ST_FULL;
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        logic ir_ok;
        logic full;
        ir_ok = (verdict_reg == ST_FULL) || (verdict_reg == ST_IRONLY);
        full = (verdict_reg == ST_FULL);
        result_valid = take && frame_end;
        result.status = verdict_reg;
        result.ir_first = ir_ok ? ir_reg[0] : 4'h0;
        result.ir_second = ir_ok ? ir_reg[1] : 4'h0;
        result.ir_third = ir_ok ? ir_reg[2] : 4'h0;
        result.chirp_strength = full ? chirp_reg : 8'h00;
        result.instruction = full ? instr_reg : 4'h0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            for (int i = 0; i < IR_KEEP; i++)
            begin
                ir_reg[i] <= 4'h0;
            end
            chirp_reg <= 8'h00;
            instr_reg <= 4'h0;
            verdict_reg <= ST_REJECT;
            cnt_reg <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            ir_reg <= ir_next;
            chirp_reg <= chirp_next;
            instr_reg <= instr_next;
            verdict_reg <= verdict_next;
            cnt_reg <= cnt_next;
            second_reg <= second_next;
        end
    end

endmodule

// File: src/radio_packet_deframe_parse.sv
// Latency: a closing word's result is shown the cycle after that word is accepted.
// Throughput: one word per cycle while rx_ready is high; parser state updates once
// per accepted word, and the result register refills while its old one is taken.
// Reset: asynchronous, active low; the parser returns to outside-frame with a
// rejected verdict and cleared fields, and no result is pending.
// Depends on rpd_pkg and rpd_parser.
module radio_packet_deframe_parse #(
    parameter int IR_COUNT = rpd_pkg::IR_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [1:0] status,
    output logic [3:0] ir_first,
    output logic [3:0] ir_second,
    output logic [3:0] ir_third,
    output logic [7:0] chirp_strength,
    output logic [3:0] instruction
);
    import rpd_pkg::*;

    logic    take;
    logic    result_valid;
    result_t result;
    logic    valid_reg;
    result_t out_reg;

    assign rx_ready = !valid_reg || res_ready;
    assign take = rx_valid && rx_ready;

    rpd_parser #(
        .IR_COUNT(IR_COUNT)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .take(take),
        .rx_byte(rx_byte),
        .result_valid(result_valid),
        .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx_ready)
        begin
            valid_reg <= result_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            out_reg <= result;
        end
    end

    assign res_valid = valid_reg;
    assign status = out_reg.status;
    assign ir_first = out_reg.ir_first;
    assign ir_second = out_reg.ir_second;
    assign ir_third = out_reg.ir_third;
    assign chirp_strength = out_reg.chirp_strength;
    assign instruction = out_reg.instruction;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for radio_packet_deframe_parse: byte streams in, frame results out.
// Depends on rpd_pkg and the block itself; keeps its own frame parser to predict results.
module tb_top;
    import rpd_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [1:0] status;
    logic [3:0] ir_first;
    logic [3:0] ir_second;
    logic [3:0] ir_third;
    logic [7:0] chirp_strength;
    logic [3:0] instruction;

    phase_t     frm_phase;
    logic [3:0] frm_ir [IR_KEEP];
    logic [7:0] frm_chirp;
    logic [3:0] frm_instr;
    status_t    frm_verdict;
    int         frm_count;

    result_t    frames_due [$];
    logic [7:0] word_buf [$];
    bit         calm = 1'b0;
    int         hold_left = 0;
    int         words_sent = 0;
    int         live_words = 0;
    int         results_seen = 0;
    int         err_count = 0;
    int         st_count [4] = '{0, 0, 0, 0};

    radio_packet_deframe_parse i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_valid),
        .rx_ready       (rx_ready),
        .rx_byte        (rx_byte),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .status         (status),
        .ir_first       (ir_first),
        .ir_second      (ir_second),
        .ir_third       (ir_third),
        .chirp_strength (chirp_strength),
        .instruction    (instruction)
    );

    always #5 clk = ~clk;

    function automatic int draw_wait();
        if (calm)
        begin
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    task automatic report(input string msg);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    function automatic void clear_frame();
        for (int i = 0; i < IR_KEEP; i++)
        begin
            frm_ir[i] = 4'h0;
        end
        frm_chirp = 8'h00;
        frm_instr = 4'h0;
        frm_verdict = ST_REJECT;
        frm_count = 0;
    endfunction

    function automatic void keep_ir(input logic [7:0] b);
        if (frm_count < IR_KEEP)
        begin
            frm_ir[frm_count] = b[3:0];
        end
        frm_count++;
        if (frm_count >= IR_COUNT_DEF)
        begin
            frm_count = 0;
            frm_phase = PH_CHIRP;
        end
        else
        begin
            frm_phase = PH_IR;
        end
    endfunction

    // Advances the frame parser by one word; returns whether the word was inside a frame.
    function automatic bit parse_rx_byte(input logic [7:0] b);
        result_t    r;
        logic [3:0] hi;
        logic [7:0] acc;
        bit         ir_ok;
        bit         live;
        hi = b[7:4];
        live = (b != BYTE_FILL) && (b == BYTE_START || frm_phase != PH_IDLE);
        if (b == BYTE_FILL)
        begin
            return live;
        end
        if (b == BYTE_START)
        begin
            clear_frame();
            frm_phase = PH_SAFE;
            return live;
        end
        if (frm_phase == PH_IDLE)
        begin
            return live;
        end
        if (b == BYTE_END)
        begin
            ir_ok = (frm_verdict == ST_FULL) || (frm_verdict == ST_IRONLY);
            r.status = frm_verdict;
            r.ir_first = ir_ok ? frm_ir[0] : 4'h0;
            r.ir_second = ir_ok ? frm_ir[1] : 4'h0;
            r.ir_third = ir_ok ? frm_ir[2] : 4'h0;
            r.chirp_strength = (frm_verdict == ST_FULL) ? frm_chirp : 8'h00;
            r.instruction = (frm_verdict == ST_FULL) ? frm_instr : 4'h0;
            frames_due.push_back(r);
            frm_phase = PH_IDLE;
            clear_frame();
            return live;
        end
        case (frm_phase)
            PH_SAFE:
            begin
                if (b == BYTE_SAFE)
                begin
                    frm_phase = PH_FIRST;
                end
                else
                begin
                    frm_phase = PH_DONE;
                end
            end
            PH_FIRST:
            begin
                if (b == BYTE_SHAKE)
                begin
                    frm_verdict = ST_SHAKE;
                    frm_phase = PH_DONE;
                end
                else if (hi == HI_IR)
                begin
                    keep_ir(b);
                end
                else
                begin
                    frm_phase = PH_DONE;
                end
            end
            PH_IR:
            begin
                keep_ir(b);
            end
            PH_CHIRP:
            begin
                if (frm_count == 0 && hi != HI_DIGIT && hi != HI_LETTER)
                begin
                    frm_chirp = 8'h00;
                    frm_verdict = ST_IRONLY;
                    frm_phase = PH_DONE;
                end
                else
                begin
                    acc = {frm_chirp[3:0], 4'h0};
                    if (hi == HI_DIGIT)
                    begin
                        acc = acc | (b - DIGIT_BASE);
                    end
                    else if (hi == HI_LETTER)
                    begin
                        acc = acc | (b - LETTER_BASE);
                    end
                    frm_chirp = acc;
                    frm_count++;
                    if (frm_count >= 2)
                    begin
                        frm_count = 0;
                        frm_phase = PH_INSTR;
                    end
                end
            end
            PH_INSTR:
            begin
                frm_instr = b[3:0];
                frm_verdict = ST_FULL;
                frm_phase = PH_DONE;
            end
            default:
            begin
            end
        endcase
        return live;
    endfunction

    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!rx_ready);
        words_sent++;
        if (parse_rx_byte(b))
        begin
            live_words++;
        end
    endtask

    task automatic send_buf();
        foreach (word_buf[i])
        begin
            send_word(word_buf[i]);
        end
        word_buf.delete();
    endtask

    task automatic wait_for_results();
        rx_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == BYTE_START || b == BYTE_END || b == BYTE_FILL);
        return b;
    endfunction

    function automatic logic [7:0] hex_char();
        logic [7:0] b;
        do b = {($urandom_range(0, 1) != 0) ? HI_LETTER : HI_DIGIT, 4'($urandom_range(0, 15))};
        while (b == BYTE_START || b == BYTE_END);
        return b;
    endfunction

    task automatic test_outside_frame();
        send_word(BYTE_END);
        send_word(BYTE_FILL);
        send_word(8'hFF);
    endtask

    task automatic test_handshake();
        send_word(BYTE_START);
        send_word(BYTE_SAFE);
        send_word(BYTE_SHAKE);
        send_word(8'h41);
        send_word(BYTE_END);
    endtask

    task automatic test_full_extremes();
        send_word(BYTE_START);
        send_word(BYTE_SAFE);
        send_word(BYTE_FILL);
        send_word(8'h2F);
        send_word(8'hF0);
        send_word(8'h0F);
        send_word(8'h46);
        send_word(8'h39);
        send_word(8'hFF);
        send_word(8'h00);
        send_word(BYTE_END);
    endtask

    task automatic test_ir_only();
        send_word(BYTE_START);
        send_word(BYTE_SAFE);
        send_word(8'h20);
        send_word(8'h01);
        send_word(8'h12);
        send_word(8'h50);
        send_word(BYTE_END);
    endtask

    task automatic test_short_frames();
        send_word(BYTE_START);
        send_word(BYTE_SAFE);
        send_word(8'h21);
        send_word(8'h22);
        send_word(8'h23);
        send_word(BYTE_END);
        send_word(BYTE_START);
        send_word(BYTE_END);
    endtask

    task automatic test_restart_reject();
        send_word(BYTE_START);
        send_word(8'h00);
        send_word(BYTE_START);
        send_word(BYTE_SAFE);
        send_word(8'h31);
        send_word(BYTE_END);
    endtask

    task automatic gen_frame();
        logic [7:0] body [$];
        logic [7:0] b;
        int         kind;
        int         cut;
        int         pos;
        kind = $urandom_range(0, 19);
        if (kind >= 18)
        begin
            repeat ($urandom_range(1, 8)) word_buf.push_back(8'($urandom_range(0, 255)));
            send_buf();
            return;
        end
        body.push_back(BYTE_SAFE);
        if (kind == 10 || kind == 11)
        begin
            body.push_back(BYTE_SHAKE);
        end
        else
        begin
            body.push_back({HI_IR, 4'($urandom_range(0, 15))});
            repeat (IR_COUNT_DEF - 1) body.push_back(plain_byte());
            if (kind == 12 || kind == 13)
            begin
                do b = plain_byte();
                while (b[7:4] == HI_DIGIT || b[7:4] == HI_LETTER);
                body.push_back(b);
            end
            else
            begin
                body.push_back(hex_char());
            end
            body.push_back(($urandom_range(0, 7) == 0) ? plain_byte() : hex_char());
            body.push_back(plain_byte());
        end
        repeat ($urandom_range(0, 2)) body.push_back(plain_byte());
        if (kind == 14 || kind == 15)
        begin
            cut = $urandom_range(0, body.size() - 1);
            while (body.size() > cut) void'(body.pop_back());
        end
        if (kind == 16 || kind == 17)
        begin
            pos = $urandom_range(0, body.size() - 1);
            body[pos] = 8'($urandom_range(0, 255));
        end
        word_buf.push_back(BYTE_START);
        foreach (body[i])
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                word_buf.push_back(BYTE_FILL);
            end
            word_buf.push_back(body[i]);
        end
        if (!((kind == 16 || kind == 17) && $urandom_range(0, 3) == 0))
        begin
            word_buf.push_back(BYTE_END);
        end
        send_buf();
    endtask

    task automatic test_random();
        bit paused;
        paused = 1'b0;
        while (words_sent < 1950)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                calm = ~calm;
            end
            gen_frame();
            if (!paused && words_sent >= 975)
            begin
                wait_for_results();
                paused = 1'b1;
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            hold_left = 0;
        end
        else if (res_valid && res_ready)
        begin
            hold_left = draw_wait();
            res_ready <= (hold_left == 0);
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= (hold_left == 0);
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            got.status = status_t'(status);
            got.ir_first = ir_first;
            got.ir_second = ir_second;
            got.ir_third = ir_third;
            got.chirp_strength = chirp_strength;
            got.instruction = instruction;
            results_seen++;
            if (frames_due.size() == 0)
            begin
                report($sformatf("result %0d arrived with none expected: status %0d",
                                 results_seen, status));
            end
            else
            begin
                want = frames_due.pop_front();
                st_count[want.status]++;
                if (got !== want)
                begin
                    report($sformatf(
                        {"result %0d: expected st %0d ir %h %h %h chirp %h instr %h,",
                         " got st %0d ir %h %h %h chirp %h instr %h"},
                        results_seen, want.status, want.ir_first, want.ir_second,
                        want.ir_third, want.chirp_strength, want.instruction,
                        got.status, got.ir_first, got.ir_second, got.ir_third,
                        got.chirp_strength, got.instruction));
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        frm_phase = PH_IDLE;
        clear_frame();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_outside_frame();
        test_handshake();
        test_full_extremes();
        test_ir_only();
        test_short_frames();
        test_restart_reject();
        wait_for_results();
        test_random();
        rx_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (frames_due.size() != 0)
        begin
            report($sformatf("%0d results never arrived", frames_due.size()));
        end
        $display("summary: %0d words sent, %0d inside frames, %0d results checked",
                 words_sent, live_words, results_seen);
        $display("summary: handshake %0d, full %0d, rejected %0d, IR only %0d, mismatches %0d",
                 st_count[ST_SHAKE], st_count[ST_FULL], st_count[ST_REJECT],
                 st_count[ST_IRONLY], err_count);
        if (err_count == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
